// File: rtl/core/crh_pkg.sv
// Shared widths, codes and types of the cell range histogram.
package crh_pkg;

	localparam int MAX_BINS         = 512;
	localparam int BIN_W            = 9;
	localparam int SAMPLE_W         = 16;
	localparam int SCALE_W          = 26;
	localparam int NBINS_W          = 10;
	localparam int COUNT_W          = 32;
	localparam int FRAC_W           = 16;
	localparam int PROD_W           = SAMPLE_W + SCALE_W;
	localparam int LANES            = 2;
	localparam int CORNERS_PER_LANE = 4;
	localparam int ROUND_Q16        = 65535;

	typedef logic [SAMPLE_W-1:0] sample_t;
	typedef logic [BIN_W-1:0]    bin_t;
	typedef logic [COUNT_W-1:0]  count_t;
	typedef logic [SCALE_W-1:0]  scale_t;
	typedef logic [NBINS_W-1:0]  nbins_t;
	typedef logic [1:0]          action_t;
	typedef logic [1:0]          cfg_index_t;

	localparam action_t ACT_ADD   = 2'd0;
	localparam action_t ACT_READ  = 2'd1;
	localparam action_t ACT_CLEAR = 2'd2;

	localparam cfg_index_t CFG_DATA_MINIMUM = 2'd0;
	localparam cfg_index_t CFG_BIN_SCALE    = 2'd1;
	localparam cfg_index_t CFG_BINS_IN_USE  = 2'd2;

	localparam sample_t RST_DATA_MINIMUM = 16'd0;
	localparam scale_t  RST_BIN_SCALE    = 26'd65536;
	localparam nbins_t  RST_BINS_IN_USE  = 10'd400;

	typedef sample_t [CORNERS_PER_LANE-1:0] lane_in_t;

	typedef struct packed {
		sample_t lo;
		sample_t hi;
	} span_t;

	typedef struct packed {
		logic walk;
		logic read;
		logic clear;
		bin_t first;
		bin_t last;
		bin_t idx;
	} bins_cmd_t;

	typedef struct packed {
		logic   idle;
		logic   done;
		count_t count;
	} bins_stat_t;

endpackage

// File: rtl/core/crh_lane.sv
// One corner lane: minimum and maximum over its share of the cell corners.
module crh_lane (
	input  logic              clk,
	input  logic              load,
	input  crh_pkg::lane_in_t corners,
	output crh_pkg::span_t    span_q
);

	crh_pkg::span_t span;

	always_comb begin
		span.lo = corners[0];
		span.hi = corners[0];
		for (int i = 1; i < crh_pkg::CORNERS_PER_LANE; i++) begin
			if (corners[i] < span.lo) span.lo = corners[i];
			if (corners[i] > span.hi) span.hi = corners[i];
		end
	end

	always_ff @(posedge clk) begin
		if (load) span_q <= span;
	end

endmodule

// File: rtl/core/crh_merge.sv
// Merge of the lane spans and mapping of the span to clamped bins.
module crh_merge (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  crh_pkg::span_t   lane_span [crh_pkg::LANES],
	input  crh_pkg::sample_t dmin,
	input  crh_pkg::scale_t  scale,
	input  crh_pkg::nbins_t  nbins,
	output logic             done,
	output crh_pkg::bin_t    first,
	output crh_pkg::bin_t    last
);

	crh_pkg::sample_t lo, hi;
	logic v_s1, v_s2, v_s3;
	logic lo_ok_s1, hi_ok_s1, lo_ok_s2, hi_ok_s2;
	crh_pkg::sample_t lo_off_s1, hi_off_s1;
	logic [crh_pkg::PROD_W-1:0] prod_lo_s2, prod_hi_s2;
	logic [crh_pkg::PROD_W:0] end_sum;
	logic [crh_pkg::SCALE_W-1:0] first_raw;
	logic [crh_pkg::PROD_W-crh_pkg::FRAC_W:0] end_raw;
	crh_pkg::bin_t top_bin;
	crh_pkg::bin_t first_s3, last_s3;

	// combine the lanes
	always_comb begin
		lo = lane_span[0].lo;
		hi = lane_span[0].hi;
		for (int i = 1; i < crh_pkg::LANES; i++) begin
			if (lane_span[i].lo < lo) lo = lane_span[i].lo;
			if (lane_span[i].hi > hi) hi = lane_span[i].hi;
		end
	end

	// round the end bin up, drop the fraction of the first bin
	always_comb begin
		end_sum   = {1'b0, prod_hi_s2} + (crh_pkg::PROD_W + 1)'(crh_pkg::ROUND_Q16);
		first_raw = lo_ok_s2 ? prod_lo_s2[crh_pkg::PROD_W-1:crh_pkg::FRAC_W] : '0;
		end_raw   = hi_ok_s2 ? end_sum[crh_pkg::PROD_W:crh_pkg::FRAC_W] : '0;
		if (nbins < crh_pkg::NBINS_W'(2))
			top_bin = crh_pkg::BIN_W'(1);
		else if (nbins > crh_pkg::NBINS_W'(crh_pkg::MAX_BINS))
			top_bin = crh_pkg::BIN_W'(crh_pkg::MAX_BINS - 1);
		else
			top_bin = crh_pkg::BIN_W'(nbins - crh_pkg::NBINS_W'(1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= start;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		lo_ok_s1  <= lo >= dmin;
		hi_ok_s1  <= hi >= dmin;
		lo_off_s1 <= lo - dmin;
		hi_off_s1 <= hi - dmin;
		lo_ok_s2   <= lo_ok_s1;
		hi_ok_s2   <= hi_ok_s1;
		prod_lo_s2 <= crh_pkg::PROD_W'(lo_off_s1) * crh_pkg::PROD_W'(scale);
		prod_hi_s2 <= crh_pkg::PROD_W'(hi_off_s1) * crh_pkg::PROD_W'(scale);
		first_s3 <= (first_raw > crh_pkg::SCALE_W'(top_bin)) ? top_bin
			: first_raw[crh_pkg::BIN_W-1:0];
		last_s3  <= (end_raw > (crh_pkg::PROD_W - crh_pkg::FRAC_W + 1)'(top_bin)) ? top_bin
			: end_raw[crh_pkg::BIN_W-1:0];
	end

	assign done  = v_s3;
	assign first = first_s3;
	assign last  = last_s3;

endmodule

// File: rtl/core/crh_bins.sv
// Bin count memory with range walker, single-bin read and clearing sweep.
module crh_bins (
	input  logic                clk,
	input  logic                arst_n,
	input  crh_pkg::bins_cmd_t  cmd,
	output crh_pkg::bins_stat_t stat
);

	localparam logic [2:0] B_CLEAR = 3'd0;
	localparam logic [2:0] B_IDLE  = 3'd1;
	localparam logic [2:0] B_WALK  = 3'd2;
	localparam logic [2:0] B_FLUSH = 3'd3;
	localparam logic [2:0] B_READ  = 3'd4;

	logic [2:0] state_q;
	crh_pkg::bin_t addr_q, stop_q, wr_addr_q, addr_nxt;
	logic wr_pend_q, done_q;
	crh_pkg::count_t rd_data_q, mem_wdata;
	crh_pkg::count_t mem [crh_pkg::MAX_BINS];
	logic mem_we, mem_re;
	crh_pkg::bin_t mem_waddr, mem_raddr;

	assign addr_nxt = addr_q + crh_pkg::BIN_W'(1);

	always_comb begin
		mem_we    = (state_q == B_CLEAR) || wr_pend_q;
		mem_waddr = (state_q == B_CLEAR) ? addr_q : wr_addr_q;
		// hold a full counter
		if (state_q == B_CLEAR)
			mem_wdata = '0;
		else if (rd_data_q == '1)
			mem_wdata = rd_data_q;
		else
			mem_wdata = rd_data_q + crh_pkg::COUNT_W'(1);
		mem_re    = (state_q == B_WALK) || ((state_q == B_IDLE) && cmd.read);
		mem_raddr = (state_q == B_WALK) ? addr_q : cmd.idx;
	end

	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_waddr] <= mem_wdata;
		if (mem_re) rd_data_q <= mem[mem_raddr];
		wr_addr_q <= addr_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= B_CLEAR;
			addr_q    <= '0;
			stop_q    <= '0;
			wr_pend_q <= 1'b0;
			done_q    <= 1'b0;
		end else begin
			wr_pend_q <= (state_q == B_WALK);
			done_q    <= 1'b0;
			case (state_q)
				B_CLEAR: begin
					addr_q <= addr_nxt;
					if (addr_q == crh_pkg::BIN_W'(crh_pkg::MAX_BINS - 1)) begin
						state_q <= B_IDLE;
						done_q  <= 1'b1;
					end
				end
				B_IDLE: begin
					if (cmd.walk) begin
						if (cmd.first < cmd.last) begin
							addr_q  <= cmd.first;
							stop_q  <= cmd.last;
							state_q <= B_WALK;
						end else begin
							done_q <= 1'b1;
						end
					end else if (cmd.read) begin
						state_q <= B_READ;
					end else if (cmd.clear) begin
						addr_q  <= '0;
						state_q <= B_CLEAR;
					end
				end
				B_WALK: begin
					addr_q <= addr_nxt;
					if (addr_nxt == stop_q) state_q <= B_FLUSH;
				end
				B_FLUSH: begin
					state_q <= B_IDLE;
					done_q  <= 1'b1;
				end
				B_READ: begin
					state_q <= B_IDLE;
					done_q  <= 1'b1;
				end
				default: begin
					state_q <= B_IDLE;
				end
			endcase
		end
	end

	assign stat.idle  = (state_q == B_IDLE);
	assign stat.done  = done_q;
	assign stat.count = rd_data_q;

endmodule

// File: rtl/core/cell_range_histogram_top.sv
// Top level of the cell range histogram: ports, sequencing and result register.
//
//  channel | signals                              | direction
//  --------+--------------------------------------+-----------
//  cfg     | cfg_valid/cfg_ready, index, data     | write into block
//  in      | in_valid/in_ready, action, corners,  | word into block
//          | bin_index                            |
//  out     | out_valid/out_ready, first_bin,      | word out of block
//          | end_bin, bin_count                   |
//
// One word is worked at a time. An add passes the lane registers, three mapping
// stages, then a read-modify-write walk over its bins through the count memory.
// A read fetches one bin; a clear sweeps the memory one entry per cycle.
// After reset the count memory is swept to zero before the first word is taken;
// config writes are taken at any time. A result waits in the output register while
// the next word is taken.
module cell_range_histogram_top (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  crh_pkg::cfg_index_t  cfg_index,
	input  crh_pkg::scale_t      cfg_data,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  crh_pkg::action_t     action,
	input  crh_pkg::sample_t     corner_a,
	input  crh_pkg::sample_t     corner_b,
	input  crh_pkg::sample_t     corner_c,
	input  crh_pkg::sample_t     corner_d,
	input  crh_pkg::sample_t     corner_e,
	input  crh_pkg::sample_t     corner_f,
	input  crh_pkg::sample_t     corner_g,
	input  crh_pkg::sample_t     corner_h,
	input  crh_pkg::bin_t        bin_index,
	output logic                 out_valid,
	input  logic                 out_ready,
	output crh_pkg::bin_t        first_bin,
	output crh_pkg::bin_t        end_bin,
	output crh_pkg::count_t      bin_count
);

	localparam logic [1:0] T_IDLE   = 2'd0;
	localparam logic [1:0] T_MAP    = 2'd1;
	localparam logic [1:0] T_BINS   = 2'd2;
	localparam logic [1:0] T_RESULT = 2'd3;

	logic [1:0] state_q;
	logic accept, out_load, map_start_q, map_done, lane_load;
	crh_pkg::action_t act_q;

	// config registers
	crh_pkg::sample_t dmin_q;
	crh_pkg::scale_t  scale_q;
	crh_pkg::nbins_t  nbins_q;

	// result under construction and the output register
	crh_pkg::bin_t   res_first_q, res_last_q, first_q, last_q;
	crh_pkg::count_t res_count_q, count_q;
	logic            out_valid_q;

	crh_pkg::lane_in_t   lane_in [crh_pkg::LANES];
	crh_pkg::span_t      lane_span [crh_pkg::LANES];
	crh_pkg::bin_t       map_first, map_last;
	crh_pkg::bins_cmd_t  cmd;
	crh_pkg::bins_stat_t stat;

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == T_IDLE) && stat.idle;
	assign accept    = in_valid && in_ready;
	assign out_load  = (state_q == T_RESULT) && (!out_valid_q || out_ready);
	assign lane_load = accept && (action == crh_pkg::ACT_ADD);

	// corners split over the lanes, four each
	assign lane_in[0] = {corner_d, corner_c, corner_b, corner_a};
	assign lane_in[1] = {corner_h, corner_g, corner_f, corner_e};

	crh_lane u_lane0 (
		.clk     (clk),
		.load    (lane_load),
		.corners (lane_in[0]),
		.span_q  (lane_span[0])
	);

	crh_lane u_lane1 (
		.clk     (clk),
		.load    (lane_load),
		.corners (lane_in[1]),
		.span_q  (lane_span[1])
	);

	crh_merge u_merge (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (map_start_q),
		.lane_span (lane_span),
		.dmin      (dmin_q),
		.scale     (scale_q),
		.nbins     (nbins_q),
		.done      (map_done),
		.first     (map_first),
		.last      (map_last)
	);

	// issue reads and clears straight from the accepted word, walks once mapped
	always_comb begin
		cmd.walk  = (state_q == T_MAP) && map_done;
		cmd.read  = accept && (action == crh_pkg::ACT_READ);
		cmd.clear = accept && (action == crh_pkg::ACT_CLEAR);
		cmd.first = map_first;
		cmd.last  = map_last;
		cmd.idx   = bin_index;
	end

	crh_bins u_bins (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.stat   (stat)
	);

	// control and config
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= T_IDLE;
			act_q       <= crh_pkg::ACT_ADD;
			map_start_q <= 1'b0;
			out_valid_q <= 1'b0;
			dmin_q      <= crh_pkg::RST_DATA_MINIMUM;
			scale_q     <= crh_pkg::RST_BIN_SCALE;
			nbins_q     <= crh_pkg::RST_BINS_IN_USE;
		end else begin
			map_start_q <= lane_load;
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					crh_pkg::CFG_DATA_MINIMUM: dmin_q  <= cfg_data[crh_pkg::SAMPLE_W-1:0];
					crh_pkg::CFG_BIN_SCALE:    scale_q <= cfg_data;
					crh_pkg::CFG_BINS_IN_USE:  nbins_q <= cfg_data[crh_pkg::NBINS_W-1:0];
					default: ;
				endcase
			end
			if (out_load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
			case (state_q)
				T_IDLE: begin
					if (accept) begin
						act_q <= action;
						case (action)
							crh_pkg::ACT_ADD:   state_q <= T_MAP;
							crh_pkg::ACT_READ:  state_q <= T_BINS;
							crh_pkg::ACT_CLEAR: state_q <= T_BINS;
							default:            state_q <= T_RESULT;
						endcase
					end
				end
				T_MAP: begin
					if (map_done) state_q <= T_BINS;
				end
				T_BINS: begin
					if (stat.done) state_q <= T_RESULT;
				end
				T_RESULT: begin
					if (out_load) state_q <= T_IDLE;
				end
				default: begin
					state_q <= T_IDLE;
				end
			endcase
		end
	end

	// result payload: zero the fields an action does not report
	always_ff @(posedge clk) begin
		if (accept) begin
			res_first_q <= '0;
			res_last_q  <= '0;
			res_count_q <= '0;
		end
		if ((state_q == T_MAP) && map_done) begin
			res_first_q <= map_first;
			res_last_q  <= map_last;
		end
		if ((state_q == T_BINS) && stat.done && (act_q == crh_pkg::ACT_READ))
			res_count_q <= stat.count;
		if (out_load) begin
			first_q <= res_first_q;
			last_q  <= res_last_q;
			count_q <= res_count_q;
		end
	end

	assign out_valid = out_valid_q;
	assign first_bin = first_q;
	assign end_bin   = last_q;
	assign bin_count = count_q;

endmodule
